// ===== rtl/core/gridding_kernel_evaluator_defines.svh =====
// assertion macros shared by the gridding kernel evaluator
`ifndef GRIDDING_KERNEL_EVALUATOR_DEFINES_SVH
`define GRIDDING_KERNEL_EVALUATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GKE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gke: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define GKE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gke: next-cycle check failed");

`endif

// ===== rtl/core/gke_pkg.sv =====
`default_nettype none

package gke_pkg;

    // register indexes on the config port
    localparam logic [2:0] REG_KERNEL_MODE     = 3'd0;
    localparam logic [2:0] REG_HALF_BASE_WIDTH = 3'd1;
    localparam logic [2:0] REG_TRIANGLE_PEAK   = 3'd2;
    localparam logic [2:0] REG_GAUSSIAN_WIDTH  = 3'd3;
    localparam logic [2:0] REG_SINC_WIDTH      = 3'd4;

    // kernel mode codes
    localparam logic [2:0] MODE_TRIANGLE   = 3'd0;
    localparam logic [2:0] MODE_TOP_HAT    = 3'd1;
    localparam logic [2:0] MODE_SINC       = 3'd2;
    localparam logic [2:0] MODE_GAUSS      = 3'd3;
    localparam logic [2:0] MODE_GAUSS_SINC = 3'd4;

    // pipeline stage map
    localparam int N_STAGES    = 42;
    localparam int ST_ABS      = 0;
    localparam int ST_DIV      = 1;
    localparam int DIV_STAGES  = 4;
    localparam int ST_PREP     = 5;
    localparam int ST_T        = 6;
    localparam int ST_T2       = 7;
    localparam int ST_HORN     = 8;
    localparam int GAUSS_TERMS = 10;
    localparam int SINC_TERMS  = 6;
    localparam int ST_GP       = ST_HORN + 3 * SINC_TERMS;
    localparam int ST_SDIV     = ST_GP + 1;
    localparam int ST_SMAG     = ST_SDIV + DIV_STAGES;
    localparam int ST_EXP      = ST_HORN + 3 * GAUSS_TERMS;
    localparam int ST_GVAL     = ST_EXP + 1;
    localparam int ST_MIX      = ST_GVAL + 1;
    localparam int ST_OUT      = ST_MIX + 1;

    // fixed point constants
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // exp(-k) in Q30 for integer k, zero past the cutoff
    localparam logic [30:0] EXPNEG_Q30 [16] = '{
        31'd1073741824, 31'd395007542, 31'd145315154, 31'd53458458,
        31'd19666268,   31'd7234816,   31'd2661540,   31'd979126,
        31'd360200,     31'd132510,    31'd48748,     31'd17933,
        31'd0,          31'd0,         31'd0,         31'd0
    };

    // divisors of the sin(t)/t series, innermost first
    localparam int SINC_DIV [SINC_TERMS] = '{156, 110, 72, 42, 20, 6};

    // one pipeline word, every stage carries the whole record
    typedef struct packed {
        logic [16:0] a;
        logic [31:0] num;
        logic [15:0] rema;
        logic [15:0] remb;
        logic [31:0] qa;
        logic [31:0] qb;
        logic [16:0] mag_simple;
        logic [35:0] qq;
        logic        gbig;
        logic        gz;
        logic [3:0]  kidx;
        logic [29:0] gf;
        logic [30:0] gacc;
        logic [31:0] gx;
        logic [31:0] gq;
        logic [30:0] gv;
        logic [16:0] gval;
        logic [31:0] u;
        logic [15:0] g;
        logic        small_arg;
        logic        neg;
        logic [31:0] t;
        logic [31:0] t2;
        logic [30:0] sacc;
        logic [31:0] sx;
        logic [31:0] sq;
        logic [31:0] srem;
        logic [31:0] squot;
        logic [16:0] smag;
        logic [17:0] mix;
        logic [17:0] value;
    } pipe_t;

endpackage

`default_nettype wire

// ===== rtl/core/gridding_kernel_evaluator.sv =====
// channel   | direction | handshake                      | payload
// ----------+-----------+--------------------------------+---------------------------------
// s_axis    | in        | s_axis_tvalid / s_axis_tready  | tdata[15:0] radius
// m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata[17:0] kernel_value
// cfg       | in        | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// one radius word per cycle sustained unless the output stalls with every stage full, 42 register stages
// latency is set by the ten-term exp series, three stages per term
// (multiply, reciprocal multiply, correct), with dividers of 8 bits per stage
// rst_n clears stage valid bits and sets config registers to their defaults asynchronously
// each stage holds only when it and every stage after it are full and
// m_axis_tready is low, so bubbles close up and nothing is lost or repeated
`default_nettype none
`include "gridding_kernel_evaluator_defines.svh"

module gridding_kernel_evaluator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] radius
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [17:0] kernel_value, [23:18] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);

    localparam int N = gke_pkg::N_STAGES;

    logic [2:0]  kernel_mode_reg;
    logic [15:0] half_base_width_reg;
    logic [16:0] triangle_peak_reg;
    logic [15:0] gaussian_width_reg;
    logic [15:0] sinc_width_reg;

    logic [15:0] h_nz;
    logic [15:0] div_a;
    logic [15:0] div_b;

    logic [N-1:0]   valid_reg;
    logic [N-1:0]   en;
    gke_pkg::pipe_t st_reg  [N];
    gke_pkg::pipe_t st_next [N];

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_mode_reg     <= 3'd0;
            half_base_width_reg <= 16'd3072;
            triangle_peak_reg   <= 17'd65536;
            gaussian_width_reg  <= 16'd1024;
            sinc_width_reg      <= 16'd1024;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                gke_pkg::REG_KERNEL_MODE:     kernel_mode_reg     <= cfg_data[2:0];
                gke_pkg::REG_HALF_BASE_WIDTH: half_base_width_reg <= cfg_data[15:0];
                gke_pkg::REG_TRIANGLE_PEAK:   triangle_peak_reg   <= cfg_data;
                gke_pkg::REG_GAUSSIAN_WIDTH:  gaussian_width_reg  <= cfg_data[15:0];
                gke_pkg::REG_SINC_WIDTH:      sinc_width_reg      <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // zero width acts as one lsb
    assign h_nz  = (half_base_width_reg == 16'd0) ? 16'd1 : half_base_width_reg;
    assign div_a = (kernel_mode_reg == gke_pkg::MODE_TRIANGLE) ? h_nz :
                   ((gaussian_width_reg == 16'd0) ? 16'd1 : gaussian_width_reg);
    assign div_b = (sinc_width_reg == 16'd0) ? 16'd1 : sinc_width_reg;

    // handshake
    assign s_axis_tready = en[0];
    assign m_axis_tvalid = valid_reg[N-1];
    assign m_axis_tdata  = {6'd0, st_reg[N-1].value};

    genvar s;
    generate
        for (s = 0; s < N; s++)
        begin : g_stage
            localparam int PREV = (s == 0) ? 0 : s - 1;
            localparam logic [63:0] LOW_MASK = (64'd1 << s) - 64'd1;
            localparam int HJ  = (s - gke_pkg::ST_HORN) / 3;
            localparam int HPH = (s - gke_pkg::ST_HORN) % 3;
            localparam bit IN_G = (s >= gke_pkg::ST_HORN) && (s < gke_pkg::ST_EXP);
            localparam bit IN_S = (s >= gke_pkg::ST_HORN) && (s < gke_pkg::ST_GP);
            localparam int HJS = (HJ >= 0 && HJ < gke_pkg::SINC_TERMS) ? HJ : 0;
            localparam int unsigned KG = (HJ >= 0 && HJ < gke_pkg::GAUSS_TERMS) ?
                                         gke_pkg::GAUSS_TERMS - HJ : 1;
            localparam int unsigned KS = gke_pkg::SINC_DIV[HJS];
            localparam logic [63:0] RG = 64'hFFFF_FFFF / KG;
            localparam logic [63:0] RS = 64'hFFFF_FFFF / KS;

            // stage enable: move unless this and all later stages are full and stalled
            assign en[s] = m_axis_tready ||
                           ((valid_reg | LOW_MASK[N-1:0]) != {N{1'b1}});

            // stage logic
            always_comb
            begin
                gke_pkg::pipe_t d;
                logic [16:0] r17a;
                logic [16:0] r17b;
                logic [32:0] r33;
                logic [15:0] f16;
                logic [19:0] z;
                logic [47:0] p48;
                logic [61:0] p62;
                logic [60:0] p61;
                logic [62:0] p63;
                logic [63:0] p64;
                logic [46:0] p47;
                logic [61:0] pe;
                logic [33:0] p34;
                logic [31:0] rr;
                logic [31:0] qc;
                logic [17:0] mag;
                logic        ng;

                d    = st_reg[PREV];
                r17a = '0;
                r17b = '0;
                r33  = '0;
                f16  = '0;
                z    = '0;
                p48  = '0;
                p62  = '0;
                p61  = '0;
                p63  = '0;
                p64  = '0;
                p47  = '0;
                pe   = '0;
                p34  = '0;
                rr   = '0;
                qc   = '0;
                mag  = '0;
                ng   = 1'b0;

                // absolute radius and divider setup
                if (s == gke_pkg::ST_ABS)
                begin
                    d = '0;
                    if (s_axis_tdata[15])
                        d.a = 17'd65536 - {1'b0, s_axis_tdata};
                    else
                        d.a = {1'b0, s_axis_tdata};
                    d.num = {d.a[15:0], 16'd0};
                end

                // two restoring dividers, 8 quotient bits per stage
                if (s >= gke_pkg::ST_DIV && s < gke_pkg::ST_DIV + gke_pkg::DIV_STAGES)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        r17a  = {d.rema, d.num[31]};
                        r17b  = {d.remb, d.num[31]};
                        d.num = {d.num[30:0], 1'b0};
                        if (r17a >= {1'b0, div_a})
                        begin
                            d.rema = 16'(r17a - {1'b0, div_a});
                            d.qa   = {d.qa[30:0], 1'b1};
                        end
                        else
                        begin
                            d.rema = r17a[15:0];
                            d.qa   = {d.qa[30:0], 1'b0};
                        end
                        if (r17b >= {1'b0, div_b})
                        begin
                            d.remb = 16'(r17b - {1'b0, div_b});
                            d.qb   = {d.qb[30:0], 1'b1};
                        end
                        else
                        begin
                            d.remb = r17b[15:0];
                            d.qb   = {d.qb[30:0], 1'b0};
                        end
                    end
                end

                // triangle, top hat, gaussian square, sinc argument fold
                if (s == gke_pkg::ST_PREP)
                begin
                    if (kernel_mode_reg == gke_pkg::MODE_TRIANGLE)
                        d.mag_simple = (d.qa < {15'd0, triangle_peak_reg}) ?
                                       17'(triangle_peak_reg - d.qa[16:0]) : 17'd0;
                    else
                        d.mag_simple = (d.a < {1'b0, h_nz}) ? 17'd65536 : 17'd0;
                    d.gbig = |d.qa[31:18];
                    d.qq   = 36'(d.qa[17:0]) * 36'(d.qa[17:0]);
                    if (kernel_mode_reg == gke_pkg::MODE_SINC)
                        d.u = {9'd0, d.a, 6'd0};
                    else
                        d.u = d.qb;
                    d.small_arg = (d.u < 32'd32768);
                    f16 = d.u[15:0];
                    if (d.small_arg)
                        d.g = f16;
                    else if (f16 <= 16'd32768)
                        d.g = f16;
                    else
                        d.g = 16'(17'd65536 - {1'b0, f16});
                    d.neg = !d.small_arg && d.u[16];
                end

                // pi scaling, gaussian exponent split
                if (s == gke_pkg::ST_T)
                begin
                    p48    = 48'(gke_pkg::PI_Q30) * 48'(d.g);
                    d.t    = p48[47:16];
                    z      = d.qq[35:16];
                    d.gz   = d.gbig || (z >= 20'd786432);
                    d.kidx = z[19:16];
                    d.gf   = {z[15:0], 14'd0};
                end

                // t squared, series seeds
                if (s == gke_pkg::ST_T2)
                begin
                    p62    = 62'(d.t[30:0]) * 62'(d.t[30:0]);
                    d.t2   = p62[61:30];
                    d.gacc = gke_pkg::Q30_ONE;
                    d.sacc = gke_pkg::Q30_ONE;
                end

                // exp(-f) nested series, one term per three stages
                if (IN_G)
                begin
                    case (HPH)
                        0:
                        begin
                            p61  = 61'(d.gf) * 61'(d.gacc);
                            d.gx = 32'(p61[60:30]);
                        end
                        1:
                        begin
                            p64  = 64'(d.gx) * RG;
                            d.gq = p64[63:32];
                        end
                        default:
                        begin
                            rr = d.gx - 32'(d.gq * 32'(KG));
                            qc = d.gq + ((rr >= 32'(KG)) ? 32'd1 : 32'd0);
                            d.gacc = 31'({1'b0, gke_pkg::Q30_ONE} - qc);
                        end
                    endcase
                end

                // sin(t)/t nested series, one term per three stages
                if (IN_S)
                begin
                    case (HPH)
                        0:
                        begin
                            p63  = 63'(d.t2) * 63'(d.sacc);
                            d.sx = p63[61:30];
                        end
                        1:
                        begin
                            p64  = 64'(d.sx) * RS;
                            d.sq = p64[63:32];
                        end
                        default:
                        begin
                            rr = d.sx - 32'(d.sq * 32'(KS));
                            qc = d.sq + ((rr >= 32'(KS)) ? 32'd1 : 32'd0);
                            d.sacc = 31'({1'b0, gke_pkg::Q30_ONE} - qc);
                        end
                    endcase
                end

                // g * P, loaded into the sinc divider
                if (s == gke_pkg::ST_GP)
                begin
                    p47     = 47'(d.g) * 47'(d.sacc);
                    d.srem  = {18'd0, p47[45:32]};
                    d.num   = p47[31:0];
                    d.squot = '0;
                end

                // g * P / u, 8 quotient bits per stage
                if (s >= gke_pkg::ST_SDIV && s < gke_pkg::ST_SDIV + gke_pkg::DIV_STAGES)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        r33   = {d.srem, d.num[31]};
                        d.num = {d.num[30:0], 1'b0};
                        if (r33 >= {1'b0, d.u})
                        begin
                            d.srem  = 32'(r33 - {1'b0, d.u});
                            d.squot = {d.squot[30:0], 1'b1};
                        end
                        else
                        begin
                            d.srem  = r33[31:0];
                            d.squot = {d.squot[30:0], 1'b0};
                        end
                    end
                end

                // sinc magnitude in Q16
                if (s == gke_pkg::ST_SMAG)
                begin
                    if (d.small_arg)
                        r33 = 33'(d.sacc) + 33'd8192;
                    else
                        r33 = 33'(d.squot) + 33'd8192;
                    d.smag = r33[30:14];
                end

                // integer part of the exponent
                if (s == gke_pkg::ST_EXP)
                begin
                    pe   = 62'(gke_pkg::EXPNEG_Q30[d.kidx]) * 62'(d.gacc);
                    d.gv = pe[60:30];
                end

                // gaussian value in Q16
                if (s == gke_pkg::ST_GVAL)
                begin
                    r33    = 33'(d.gv) + 33'd8192;
                    d.gval = d.gz ? 17'd0 : r33[30:14];
                end

                // gaussian times sinc magnitude
                if (s == gke_pkg::ST_MIX)
                begin
                    p34   = 34'(d.gval) * 34'(d.smag);
                    d.mix = 18'((35'(p34) + 35'd32768) >> 16);
                end

                // mode select and saturation
                if (s == gke_pkg::ST_OUT)
                begin
                    case (kernel_mode_reg)
                        gke_pkg::MODE_TRIANGLE,
                        gke_pkg::MODE_TOP_HAT:
                        begin
                            mag = {1'b0, d.mag_simple};
                            ng  = 1'b0;
                        end
                        gke_pkg::MODE_SINC:
                        begin
                            mag = {1'b0, d.smag};
                            ng  = d.neg;
                        end
                        gke_pkg::MODE_GAUSS:
                        begin
                            mag = {1'b0, d.gval};
                            ng  = 1'b0;
                        end
                        gke_pkg::MODE_GAUSS_SINC:
                        begin
                            mag = d.mix;
                            ng  = d.neg;
                        end
                        default:
                        begin
                            mag = 18'd0;
                            ng  = 1'b0;
                        end
                    endcase
                    if (ng)
                    begin
                        if (mag > 18'd131072)
                            mag = 18'd131072;
                        d.value = 18'd0 - mag;
                    end
                    else
                    begin
                        if (mag > 18'd131071)
                            mag = 18'd131071;
                        d.value = mag;
                    end
                end

                st_next[s] = d;
            end

            // stage valid bit
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[s] <= 1'b0;
                else if (en[s])
                    valid_reg[s] <= (s == 0) ? s_axis_tvalid : valid_reg[PREV];
            end

            // stage payload
            always_ff @(posedge clk)
            begin
                if (en[s])
                    st_reg[s] <= st_next[s];
            end
        end
    endgenerate

    // checks
    `GKE_ASSERT_NEXT(a_accept_fills, s_axis_tvalid && s_axis_tready, valid_reg[0])
    `GKE_ASSERT_NOW(a_drain_ready, m_axis_tready, s_axis_tready)
    `GKE_ASSERT_NOW(a_bad_mode_zero,
        m_axis_tvalid && (kernel_mode_reg > gke_pkg::MODE_GAUSS_SINC),
        m_axis_tdata == 24'd0)
    `GKE_ASSERT_NOW(a_top_hat_levels,
        m_axis_tvalid && (kernel_mode_reg == gke_pkg::MODE_TOP_HAT),
        (m_axis_tdata == 24'd0) || (m_axis_tdata == 24'd65536))

endmodule

`default_nettype wire
